// ===== rtl/bkdc_pkg.sv =====
// Package for the base-k digit converter: field widths, register indexes
// and reset values. No dependencies.
`default_nettype none

package bkdc_pkg;

    // Field and register widths.
    localparam int VALUE_W   = 32;
    localparam int DIGIT_W   = 16;
    localparam int COUNT_W   = 6;
    localparam int CFG_IDX_W = 1;

    // Default depth of the digit store.
    localparam int MAX_DIGITS_DEF = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

    // Register reset values.
    localparam logic [DIGIT_W-1:0] RADIX_RST = 16'd2;
    localparam logic [COUNT_W-1:0] COUNT_RST = 6'd32;

    // Status handed from the divider to the sequencer.
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [DIGIT_W-1:0] remainder;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== rtl/base_k_digit_conversion.sv =====
// Top level of the base-k digit converter: configuration registers, the
// digit sequencer, the shared divider and the digit store.
// Depends on bkdc_pkg, bkdc_div and bkdc_ram.
//
//  Channel  Direction  Handshake            Payload
//  input    in         i_valid / o_ready    i_value[31:0]
//  output   out        o_valid / i_ready    o_digit[15:0], o_last
//  config   in         i_cfg_we             i_cfg_addr[0], i_cfg_data[15:0]
//
// For a value with an effective digit count n, the shared bit-serial divider
// produces the n digits one after another (32 quotient bits each, plus the
// write of the remainder into the store); each digit is then read back from
// the store, most significant first, and offered.
// Reset is synchronous and active low; the store needs no clearing.
// A stalled receiver holds the sequencer; no new value is taken until the
// last digit of the run has been transferred.
`default_nettype none

module base_k_digit_conversion #(
    parameter int MAX_DIGITS = bkdc_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [bkdc_pkg::VALUE_W-1:0]   i_value,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [bkdc_pkg::DIGIT_W-1:0]   o_digit,
    output logic                                o_last,
    input  wire logic                           i_cfg_we,
    input  wire logic [bkdc_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [bkdc_pkg::DIGIT_W-1:0]   i_cfg_data
);

    import bkdc_pkg::*;

    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int NW = COUNT_W + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_RD   = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [DIGIT_W-1:0] r_radix;
    logic [COUNT_W-1:0] r_count;
    logic [DIGIT_W-1:0] r_k, n_k;
    logic [CW-1:0]      r_n, n_n;
    logic [CW-1:0]      r_pos, n_pos;
    logic [DIGIT_W-1:0] eff_radix;
    logic [NW-1:0]      eff_count;
    logic [CW-1:0]      pos_inc;
    logic               accept;
    logic               div_start;
    logic [VALUE_W-1:0] div_dividend;
    logic [DIGIT_W-1:0] div_divisor;
    t_div_stat          div_stat;
    logic               ram_we;
    logic               ram_re;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RST;
            r_count <= COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_RADIX: r_radix <= i_cfg_data;
                CFG_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Bases below two act as two; the digit count is clamped to 1..MAX_DIGITS.
    assign eff_radix = (r_radix[DIGIT_W-1:1] == '0) ? RADIX_RST : r_radix;

    always_comb begin
        if (r_count == '0) begin
            eff_count = NW'(1);
        end else if ({1'b0, r_count} > NW'(MAX_DIGITS)) begin
            eff_count = NW'(MAX_DIGITS);
        end else begin
            eff_count = {1'b0, r_count};
        end
    end

    assign accept  = (r_state == S_IDLE) && i_valid;
    assign pos_inc = r_pos + 1'b1;

    // Sequencer: divide digit by digit, then read the store back top down.
    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_n          = r_n;
        n_pos        = r_pos;
        div_start    = 1'b0;
        div_dividend = div_stat.quotient;
        div_divisor  = r_k;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_k          = eff_radix;
                    n_n          = CW'(eff_count);
                    n_pos        = '0;
                    div_start    = 1'b1;
                    div_dividend = i_value;
                    div_divisor  = eff_radix;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    ram_we = 1'b1;
                    if (pos_inc == r_n) begin
                        n_pos   = r_pos;
                        n_state = S_RD;
                    end else begin
                        n_pos     = pos_inc;
                        div_start = 1'b1;
                    end
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    if (r_pos == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos   = r_pos - 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_n     <= '0;
            r_k     <= RADIX_RST;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_n     <= n_n;
            r_k     <= n_k;
        end
    end

    // Shared divider.
    bkdc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat)
    );

    // Digit store, least significant digit at address zero.
    bkdc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (div_stat.remainder),
        .i_re    (ram_re),
        .i_raddr (r_pos[AW-1:0]),
        .o_rdata (o_digit)
    );

    // The store's read register doubles as the output register.
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_last  = (r_pos == '0);

endmodule

`default_nettype wire

// ===== rtl/bkdc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module bkdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bkdc_div.sv =====
// Iterative restoring divider: 32-bit dividend by 16-bit divisor, one
// quotient bit per cycle. Depends on bkdc_pkg.
`default_nettype none

module bkdc_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [bkdc_pkg::VALUE_W-1:0]  i_dividend,
    input  wire logic [bkdc_pkg::DIGIT_W-1:0]  i_divisor,
    output bkdc_pkg::t_div_stat                o_stat
);

    import bkdc_pkg::*;

    localparam int CNT_W = $clog2(VALUE_W);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [VALUE_W-1:0] r_q, n_q;
    logic [DIGIT_W-1:0] r_rem, n_rem;
    logic [DIGIT_W-1:0] r_div, n_div;
    logic [DIGIT_W:0]   shifted;
    logic [DIGIT_W:0]   diff;
    logic               ge;

    // One restoring step: shift in the next dividend bit, trial subtract.
    assign shifted = {r_rem, r_q[VALUE_W-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign ge      = (shifted >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
            n_q   = {r_q[VALUE_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_stat.done      = r_done;
    assign o_stat.quotient  = r_q;
    assign o_stat.remainder = r_rem;

endmodule

`default_nettype wire

// ===== dv/tb_base_k_digit_conversion.sv =====
// Self-checking testbench for base_k_digit_conversion: directed and random values
// under many radix and digit-count settings, with random gaps and stalls on both channels.
// Depends on bkdc_pkg and the base_k_digit_conversion RTL.
module tb_base_k_digit_conversion;
    timeunit 1ns;
    timeprecision 1ps;

    import bkdc_pkg::*;

    localparam int          RUN_DIGITS  = 32;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int          SETTLE      = 40;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_digit_out;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_valid    = 1'b0;
    logic                 o_ready;
    logic [VALUE_W-1:0]   i_value    = '0;
    logic                 o_valid;
    logic                 i_ready    = 1'b0;
    logic [DIGIT_W-1:0]   o_digit;
    logic                 o_last;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = CFG_RADIX;
    logic [DIGIT_W-1:0]   i_cfg_data = '0;

    // Shadow copy of the configuration registers.
    logic [DIGIT_W-1:0] radix_setting = RADIX_RST;
    logic [COUNT_W-1:0] count_setting = COUNT_RST;

    t_digit_out  pending_digits[$];
    int unsigned error_count     = 0;
    int unsigned digits_checked  = 0;
    int unsigned values_sent     = 0;
    int unsigned settings_used   = 0;
    int unsigned cycle_count     = 0;
    int unsigned ready_hold      = 0;
    bit          no_gaps         = 1'b0;

    base_k_digit_conversion dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_digit    (o_digit),
        .o_last     (o_last),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Split a value into its kept base-k digits and queue them, most significant first.
    function automatic void predict_digit_run(input logic [VALUE_W-1:0] value);
        int unsigned        k;
        int unsigned        n;
        int unsigned        pos;
        logic [VALUE_W-1:0] quotient;
        logic [DIGIT_W-1:0] digits[RUN_DIGITS];
        t_digit_out         item;
        k = (radix_setting < 2) ? 2 : radix_setting;
        n = (count_setting == 0) ? 1 : count_setting;
        if (n > RUN_DIGITS)
            n = RUN_DIGITS;
        quotient = value;
        for (int i = 0; i < n; i++) begin
            digits[i] = DIGIT_W'(quotient % k);
            quotient  = quotient / k;
        end
        for (int i = 0; i < n; i++) begin
            pos        = n - 1 - i;
            item.digit = digits[pos];
            item.last  = (pos == 0);
            pending_digits.push_back(item);
        end
    endfunction

    function automatic int unsigned draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 6);
    endfunction

    // Offer one value and wait for its transfer; valid stays high on return.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        predict_digit_run(value);
        values_sent++;
    endtask

    // Stop offering and wait until every expected digit has arrived.
    task automatic drain_block();
        i_valid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write, only issued while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DIGIT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_RADIX)
            radix_setting = data;
        else
            count_setting = data[COUNT_W-1:0];
        settings_used++;
        @(posedge i_clk);
    endtask

    task automatic set_format(input logic [DIGIT_W-1:0] radix, input logic [DIGIT_W-1:0] count);
        write_reg(CFG_RADIX, radix);
        write_reg(CFG_COUNT, count);
    endtask

    // Receiver: random stall before each digit, plus an optional long hold-off.
    initial begin
        int unsigned stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (ready_hold > 0) begin
                i_ready <= 1'b0;
                repeat (ready_hold) @(posedge i_clk);
                ready_hold = 0;
            end
            stall = draw_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Compare each transferred digit with the oldest expectation.
    always @(posedge i_clk) begin
        t_digit_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_digits.size() == 0) begin
                $error("unexpected digit transfer: digit=%0d last=%0b", o_digit, o_last);
                error_count++;
            end else begin
                want = pending_digits.pop_front();
                if (o_digit !== want.digit) begin
                    $error("digit: expected %0d, got %0d", want.digit, o_digit);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    error_count++;
                end
                digits_checked++;
            end
        end
    end

    // Reset values: radix 2, 32 digits.
    task automatic test_reset_format();
        send_value(32'h0000_0000);
        send_value(32'hFFFF_FFFF);
        send_value(32'h0000_0001);
        send_value(32'h8000_0000);
        drain_block();
    endtask

    // Radix extremes, including the values below two that act as two.
    task automatic test_radix_extremes();
        set_format(16'd0, 16'd8);
        send_value(32'h0000_00A5);
        drain_block();
        set_format(16'd1, 16'd8);
        send_value(32'h0000_005A);
        drain_block();
        set_format(16'hFFFF, 16'd3);
        send_value(32'hFFFF_FFFF);
        send_value(32'hFFFE_1234);
        drain_block();
        set_format(16'd10, 16'd10);
        send_value(32'hFFFF_FFFF);
        drain_block();
        set_format(16'd16, 16'd8);
        send_value(32'hDEAD_BEEF);
        drain_block();
    endtask

    // Digit counts of zero, one, saturating values and a truncated value.
    task automatic test_count_extremes();
        set_format(16'd7, 16'd0);
        send_value(32'd48);
        drain_block();
        write_reg(CFG_COUNT, 16'd1);
        send_value(32'd0);
        send_value(32'hFFFF_FFFF);
        drain_block();
        write_reg(CFG_COUNT, 16'd33);
        send_value(32'h1234_5678);
        drain_block();
        // Upper data bits fall outside the 6-bit register and leave 63.
        write_reg(CFG_COUNT, 16'hFFFF);
        send_value(32'd0);
        drain_block();
        set_format(16'd10, 16'd3);
        send_value(32'd123456);
        send_value(32'd7);
        drain_block();
    endtask

    // Long receiver hold-off while the sender keeps offering, so the input stalls.
    task automatic test_output_backpressure();
        set_format(16'd2, 16'd32);
        ready_hold = 2500;
        send_value(32'hA5A5_5A5A);
        send_value(32'h0F0F_F0F0);
        send_value(32'h7FFF_FFFF);
        drain_block();
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 255);
            1: return $urandom() >> $urandom_range(0, 31);
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Random values over a series of register settings.
    task automatic test_random_values();
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: set_format(16'd2, 16'd32);
                1: set_format(16'hFFFF, 16'd2);
                2: set_format(16'd10, 16'd10);
                3: set_format(16'd16, 16'd8);
                4: set_format(DIGIT_W'($urandom_range(0, 1)),
                              DIGIT_W'($urandom_range(33, 63)));
                5: set_format(16'd3, 16'd21);
                6: set_format(DIGIT_W'($urandom_range(2, 40)),
                              DIGIT_W'($urandom_range(0, 12)));
                default: set_format(DIGIT_W'($urandom_range(2, 65535)),
                                    DIGIT_W'($urandom_range(1, 12)));
            endcase
            // One stretch runs without any idle cycles on either side.
            no_gaps = (phase == 2);
            repeat (21) send_value(pick_value());
            drain_block();
        end
        no_gaps = 1'b0;
    endtask

    // Test sequence.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_format();
        test_radix_extremes();
        test_count_extremes();
        test_output_backpressure();
        test_random_values();
        drain_block();
        repeat (SETTLE) @(posedge i_clk);
        $display("Converted %0d values into %0d checked digits over %0d register writes.",
                 values_sent, digits_checked, settings_used);
        if (error_count == 0 && pending_digits.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
